// ===== hw/rtl/pim_pkg.sv =====
// Package for the priority interrupt masker: sizes, opcodes, sequencer states.
// No dependencies.
package pim_pkg;
  localparam int unsigned Cores       = 4;
  localparam int unsigned LocalLines  = 32;
  localparam int unsigned SharedLines = 72;
  localparam int unsigned CascadeBit  = 8;
  localparam int unsigned TotalLines  = LocalLines + SharedLines;
  localparam int unsigned LocDepth    = Cores * LocalLines;
  localparam int unsigned LocAw       = $clog2(LocDepth);
  localparam int unsigned ShAw        = $clog2(SharedLines);
  localparam logic [7:0]  UnusedPrio  = 8'hFF;

  typedef enum logic [2:0] {
    OpSetLine  = 3'd0,
    OpAccept   = 3'd1,
    OpEoi      = 3'd2,
    OpSetPrio  = 3'd3,
    OpReadEn   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    StIdle, StSetLine, StLookup, StPrioWait, StMask, StDone
  } state_e;

  // Highest set bit of a 32-bit word.
  function automatic logic [5:0] top_bit(input logic [31:0] w);
    logic [5:0] r;
    r = 6'd32;
    for (int b = 0; b < 32; b++) if (w[b]) r = 6'(b);
    return r;
  endfunction

  function automatic logic has_local_en(input logic [6:0] n);
    return (n < 7'(LocalLines)) && (n < 7'd10) && (n != 7'd8);
  endfunction
endpackage

// ===== hw/rtl/pim_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module pim_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== hw/rtl/priority_interrupt_masker.sv =====
// Priority interrupt masker top level.
// Flow from accept: read enable, unknown op and spurious accept go straight to done;
// set line writes one core per cycle, then done and strobe; eoi/set priority re-mask;
// accept re-masks after the table lookup and its read wait. The re-mask takes the
// lines one per cycle: 32 local, 104 for core 0.
// One beat at a time; busy high until the strobe, so a new beat is taken at the
// earliest in the strobe cycle. Receiver cannot stall.
// Reset: tables read as 255 via per-entry valid bits, core priorities and enables 0.
module priority_interrupt_masker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op_i,
  input  logic [1:0]  core_i,
  input  logic [6:0]  line_i,
  input  logic        line_enable_i,
  input  logic [7:0]  priority_req_i,
  input  logic [3:0]  affinity_i,
  input  logic [31:0] local_sources_i,
  input  logic [31:0] pending_bank0_i,
  input  logic [31:0] pending_bank1_i,
  input  logic [7:0]  basic_pending_i,
  output logic        result_valid_o,
  output logic [6:0]  vector_o,
  output logic        spurious_o,
  output logic        mailbox_clear_o,
  output logic [7:0]  saved_priority_o,
  output logic        enabled_o
);
  import pim_pkg::*;

  state_e state_q, state_d;
  logic [1:0] core_q;
  logic [6:0] line_q;
  logic       len_q;
  logic [7:0] preq_q;
  logic [3:0] aff_q;
  logic [1:0] pcnt_q;     // set-line core index
  logic [6:0] scan_q;     // re-mask line index
  logic [7:0] thr_q;      // threshold during re-mask
  logic [7:0] cprio_q [Cores];
  logic [Cores-1:0][LocalLines-1:0] len_bits_q;
  logic [SharedLines-1:0] sh_en_q;
  logic [LocDepth-1:0]    lvalid_q;
  logic [SharedLines-1:0] svalid_q;
  logic [6:0] vec_q;
  logic       spur_q, mbx_q, en_q;
  logic [7:0] saved_q;
  logic       rv_q;

  // raised vector search
  logic [5:0] tl, t0, t1, tb, tr;
  logic [6:0] rvec;
  logic       rnone;
  always_comb begin
    tl = top_bit(local_sources_i);
    t0 = top_bit(pending_bank0_i);
    t1 = top_bit(pending_bank1_i);
    tb = top_bit({24'd0, basic_pending_i});
    tr = top_bit(local_sources_i & ~(32'd1 << CascadeBit));
    rnone = 1'b0;
    rvec  = 7'd0;
    priority if (tl != 6'(CascadeBit)) begin
      rnone = tl[5]; rvec = {2'b0, tl[4:0]};
    end else if (!t0[5]) rvec = 7'(LocalLines) + {2'b0, t0[4:0]};
    else if (!t1[5]) rvec = 7'(LocalLines + 32) + {2'b0, t1[4:0]};
    else if (!tb[5]) rvec = 7'(LocalLines + 64) + {2'b0, tb[4:0]};
    else begin
      rnone = tr[5]; rvec = {2'b0, tr[4:0]};
    end
  end

  // memory ports
  logic             lwe, swe;
  logic [LocAw-1:0] laddr;
  logic [ShAw-1:0]  saddr;
  logic [7:0]       lwdata, lrdata, srdata;
  logic [6:0]       aline;  // line addressed this cycle
  logic [1:0]       acore;
  logic             rd_loc_q, rd_valid_q;

  always_comb begin
    aline = line_q;
    acore = core_q;
    unique case (state_q)
      StSetLine: acore = pcnt_q;
      StMask:    aline = scan_q;
      default: ;
    endcase
  end
  assign laddr = LocAw'({acore, aline[4:0]});
  assign saddr = (aline >= 7'(LocalLines)) ? ShAw'(aline - 7'(LocalLines)) : '0;
  logic [7:0] setprio;
  assign setprio = len_q ? preq_q : UnusedPrio;
  logic in_sh;
  assign in_sh = (line_q >= 7'(LocalLines)) && (line_q < 7'(TotalLines));
  assign lwe   = (state_q == StSetLine) && aff_q[pcnt_q] && (line_q < 7'(LocalLines));
  assign swe   = (state_q == StSetLine) && aff_q[pcnt_q] && in_sh;
  assign lwdata = setprio;

  pim_ram #(.Width(8), .Depth(LocDepth)) u_loc (
    .clk_i, .we_i(lwe), .addr_i(laddr), .wdata_i(lwdata), .rdata_o(lrdata));
  pim_ram #(.Width(8), .Depth(SharedLines)) u_sh (
    .clk_i, .we_i(swe), .addr_i(saddr), .wdata_i(setprio), .rdata_o(srdata));

  // read data with reset value and out-of-table handling
  logic [7:0] rprio;
  always_comb begin
    if (!rd_valid_q) rprio = UnusedPrio;
    else if (rd_loc_q) rprio = lrdata;
    else rprio = srdata;
  end

  logic [6:0] last_line;
  assign last_line = (core_q == 2'd0) ? 7'(TotalLines - 1) : 7'(LocalLines - 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (start) begin
        if (32'(core_i) >= Cores) state_d = StDone;
        else begin
          unique case (op_i)
            OpSetLine: state_d = StSetLine;
            OpAccept:  state_d = rnone ? StDone : StLookup;
            OpEoi, OpSetPrio: state_d = StMask;
            default:   state_d = StDone;
          endcase
        end
      end
      StSetLine:  if (pcnt_q == 2'(Cores - 1)) state_d = StDone;
      StLookup:   state_d = StPrioWait;
      StPrioWait: state_d = StMask;
      StMask:     if (scan_q == last_line) state_d = StPrioWait;
      StDone:     state_d = StIdle;
      default:    state_d = StIdle;
    endcase
    // StPrioWait after StMask: final writeback then done
    if (state_q == StPrioWait && rv_q) state_d = StDone;
  end

  assign busy = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      for (int i = 0; i < Cores; i++) cprio_q[i] <= '0;
      len_bits_q <= '0;
      sh_en_q <= '0;
      lvalid_q <= '0;
      svalid_q <= '0;
      result_valid_o <= 1'b0;
      rv_q <= 1'b0;
      pcnt_q <= '0;
      scan_q <= '0;
    end else begin
      state_q <= state_d;
      result_valid_o <= (state_q == StDone);
      rd_loc_q   <= aline < 7'(LocalLines);
      rd_valid_q <= (aline < 7'(LocalLines)) ? lvalid_q[laddr]
                  : (aline < 7'(TotalLines)) ? svalid_q[saddr] : 1'b0;
      unique case (state_q)
        StIdle: if (start) begin
          core_q <= core_i; line_q <= line_i;
          len_q <= line_enable_i; preq_q <= priority_req_i;
          aff_q <= affinity_i; pcnt_q <= '0; scan_q <= '0; rv_q <= 1'b0;
          vec_q <= '0; spur_q <= 1'b0; mbx_q <= 1'b0; en_q <= 1'b0;
          saved_q <= '0;
          if (32'(core_i) < Cores) begin
            unique case (op_i)
              OpAccept: begin
                spur_q <= rnone;
                if (!rnone) begin
                  vec_q <= rvec; line_q <= rvec;
                  mbx_q <= (rvec >= 7'd4) && (rvec < 7'd8);
                  saved_q <= cprio_q[core_i];
                end
              end
              OpEoi, OpSetPrio: begin
                cprio_q[core_i] <= priority_req_i;
                thr_q <= priority_req_i;
              end
              OpReadEn: begin
                if (line_i < 7'(LocalLines))
                  en_q <= has_local_en(line_i) && len_bits_q[core_i][line_i[4:0]];
                else if (line_i < 7'(TotalLines))
                  en_q <= sh_en_q[ShAw'(line_i - 7'(LocalLines))];
              end
              default: ;
            endcase
          end
        end
        StSetLine: begin
          pcnt_q <= pcnt_q + 2'd1;
          if (aff_q[pcnt_q]) begin
            if (line_q < 7'(LocalLines)) begin
              lvalid_q[laddr] <= 1'b1;
              if (has_local_en(line_q))
                len_bits_q[pcnt_q][line_q[4:0]] <= len_q && (setprio != UnusedPrio)
                                                   && (setprio > cprio_q[pcnt_q]);
            end else if (in_sh) begin
              svalid_q[saddr] <= 1'b1;
              sh_en_q[saddr] <= len_q && (setprio != UnusedPrio)
                                && (setprio > cprio_q[pcnt_q]);
            end
          end
        end
        StPrioWait: if (!rv_q) begin
          // priority of accepted line arrives now
          cprio_q[core_q] <= rprio;
          thr_q <= rprio;
          rv_q <= 1'b1;
        end
        StMask: begin
          // apply the enable for the previous line (read returned now)
          if (scan_q != 7'd0 && rprio != UnusedPrio) begin
            if ((scan_q - 7'd1) < 7'(LocalLines)) begin
              if (has_local_en(scan_q - 7'd1))
                len_bits_q[core_q][5'(scan_q - 7'd1)] <= rprio > thr_q;
            end else
              sh_en_q[ShAw'(scan_q - 7'd1 - 7'(LocalLines))] <= rprio > thr_q;
          end
          scan_q <= scan_q + 7'd1;
          if (scan_q == last_line) rv_q <= 1'b1;
        end
        default: ;
      endcase
      // writeback of the last scanned line
      if (state_q == StPrioWait && rv_q && rprio != UnusedPrio) begin
        if (last_line < 7'(LocalLines)) begin
          if (has_local_en(last_line))
            len_bits_q[core_q][last_line[4:0]] <= rprio > thr_q;
        end else
          sh_en_q[ShAw'(last_line - 7'(LocalLines))] <= rprio > thr_q;
      end
    end
  end

  assign vector_o = vec_q;
  assign spurious_o = spur_q;
  assign mailbox_clear_o = mbx_q;
  assign saved_priority_o = saved_q;
  assign enabled_o = en_q;

  // Assertions
  a_strobe_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |=> result_valid_o) else $error("missing strobe");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> state_q == StIdle) else $error("strobe while busy");
  a_spur_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && spurious_o) |-> vector_o == 7'd0) else $error("spurious vector");
endmodule

// ===== tb/sv/priority_interrupt_masker_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for priority_interrupt_masker: directed and random beats,
// with a scoreboard that predicts each result from its own copy of the tables.
// Depends on pim_pkg and the priority_interrupt_masker RTL.
module priority_interrupt_masker_tb;
  import pim_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 250;   // longest beat is an accept on core 0
  localparam int unsigned RandomBeats   = 1800;

  typedef struct {
    logic [2:0]  op;
    logic [1:0]  core;
    logic [6:0]  line;
    logic        line_en;
    logic [7:0]  prio;
    logic [3:0]  aff;
    logic [31:0] local_src;
    logic [31:0] bank0;
    logic [31:0] bank1;
    logic [7:0]  basic;
  } irq_req_t;

  typedef struct {
    logic [6:0] vector;
    logic       spurious;
    logic       mbox_clear;
    logic [7:0] saved_prio;
    logic       enabled;
  } irq_resp_t;

  // Predicts the masker's answers and holds the ones still owed by the DUT.
  class irq_scoreboard;
    logic [7:0]  loc_prio [Cores][LocalLines];
    logic [7:0]  sh_prio [SharedLines];
    logic [7:0]  core_prio [Cores];
    logic [31:0] loc_en [Cores];
    logic        sh_en [SharedLines];
    irq_resp_t   owed_q[$];
    int          errors;

    function new();
      foreach (loc_prio[c, n]) loc_prio[c][n] = UnusedPrio;
      foreach (sh_prio[n]) sh_prio[n] = UnusedPrio;
      foreach (core_prio[c]) core_prio[c] = '0;
      foreach (loc_en[c]) loc_en[c] = '0;
      foreach (sh_en[n]) sh_en[n] = 1'b0;
      errors = 0;
    endfunction

    function int line_prio(int c, int n);
      if (n < LocalLines) return loc_prio[c][n];
      if (n < TotalLines) return sh_prio[n - LocalLines];
      return UnusedPrio;
    endfunction

    function bit owns_local_en(int n);
      return n < LocalLines && n < 10 && n != 8;
    endfunction

    function void set_enable(int n, int c, bit en);
      if (n < LocalLines) begin
        if (owns_local_en(n)) loc_en[c][n] = en;
      end else if (n < TotalLines) begin
        sh_en[n - LocalLines] = en;
      end
    endfunction

    // Core 0 rescans shared lines too; other cores only their locals.
    function void remask(int c);
      int last;
      int p;
      last = (c == 0) ? TotalLines : LocalLines;
      for (int n = 0; n < last; n++) begin
        p = line_prio(c, n);
        if (p != UnusedPrio) set_enable(n, c, p > core_prio[c]);
      end
    endfunction

    function int msb_of(logic [31:0] w);
      for (int b = 31; b >= 0; b--) if (w[b]) return b;
      return -1;
    endfunction

    // Highest raised source; the cascade bit defers to bank0, bank1, basic.
    function int raised_line(irq_req_t r);
      int v;
      logic [31:0] rest;
      v = msb_of(r.local_src);
      if (v != CascadeBit) return v;
      if (r.bank0 != 0) return LocalLines + msb_of(r.bank0);
      if (r.bank1 != 0) return LocalLines + 32 + msb_of(r.bank1);
      if (r.basic != 0) return LocalLines + 64 + msb_of({24'd0, r.basic});
      rest = r.local_src;
      rest[CascadeBit] = 1'b0;
      return msb_of(rest);
    endfunction

    function void note_item(irq_req_t r);
      irq_resp_t e;
      int c;
      int v;
      int prio;
      bit en;
      e = '{default: '0};
      c = r.core;
      case (r.op)
        OpSetLine: begin
          prio = r.line_en ? r.prio : UnusedPrio;
          for (int p = 0; p < Cores; p++) begin
            if (r.aff[p]) begin
              en = (prio != UnusedPrio) && (prio > core_prio[p]);
              if (r.line < LocalLines) loc_prio[p][r.line] = 8'(prio);
              else if (r.line < TotalLines) sh_prio[r.line - LocalLines] = 8'(prio);
              set_enable(r.line, p, en && r.line_en);
            end
          end
        end
        OpAccept: begin
          v = raised_line(r);
          if (v < 0) begin
            e.spurious = 1'b1;   // nothing raised: state untouched
          end else begin
            e.vector     = 7'(v);
            e.mbox_clear = (v >= 4 && v < 8);
            e.saved_prio = core_prio[c];
            core_prio[c] = 8'(line_prio(c, v));
            remask(c);
          end
        end
        OpEoi, OpSetPrio: begin
          core_prio[c] = r.prio;
          remask(c);
        end
        OpReadEn: begin
          if (r.line < LocalLines) begin
            if (owns_local_en(r.line)) e.enabled = loc_en[c][r.line];
          end else if (r.line < TotalLines) begin
            e.enabled = sh_en[r.line - LocalLines];
          end
        end
        default: ;   // unknown op: all-zero answer
      endcase
      owed_q.push_back(e);
    endfunction

    function void report(string field, int exp_v, int act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, act_v);
      end
    endfunction

    function void check_result(irq_resp_t a);
      irq_resp_t e;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual vector %0h", $time, a.vector);
        return;
      end
      e = owed_q.pop_front();
      report("vector", e.vector, a.vector);
      report("spurious", e.spurious, a.spurious);
      report("mailbox_clear", e.mbox_clear, a.mbox_clear);
      report("saved_priority", e.saved_prio, a.saved_prio);
      report("enabled", e.enabled, a.enabled);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  op_i = '0;
  logic [1:0]  core_i = '0;
  logic [6:0]  line_i = '0;
  logic        line_enable_i = 1'b0;
  logic [7:0]  priority_req_i = '0;
  logic [3:0]  affinity_i = '0;
  logic [31:0] local_sources_i = '0;
  logic [31:0] pending_bank0_i = '0;
  logic [31:0] pending_bank1_i = '0;
  logic [7:0]  basic_pending_i = '0;
  logic        result_valid_o;
  logic [6:0]  vector_o;
  logic        spurious_o;
  logic        mailbox_clear_o;
  logic [7:0]  saved_priority_o;
  logic        enabled_o;

  irq_scoreboard irq_sb = new();
  int unsigned   quiet_cycles = 0;
  int unsigned   idle_pct = 0;

  always #2 clk_i = ~clk_i;

  priority_interrupt_masker dut (.*);

  // Result strobe: at most one beat per cycle, no backpressure possible.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      irq_sb.check_result('{vector_o, spurious_o, mailbox_clear_o, saved_priority_o,
                            enabled_o});
  end

  // Watchdog: trips when neither side moves a beat for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic irq_req_t mk(logic [2:0] op, logic [1:0] core, logic [6:0] line,
                                  logic en, logic [7:0] prio, logic [3:0] aff,
                                  logic [31:0] src, logic [31:0] b0, logic [31:0] b1,
                                  logic [7:0] bas);
    irq_req_t r;
    r = '{op, core, line, en, prio, aff, src, b0, b1, bas};
    return r;
  endfunction

  // Sparse words make the cascade walk reach every bank.
  function automatic logic [31:0] sparse_word();
    case ($urandom_range(3))
      0: return '0;
      1: return 32'd1 << $urandom_range(31);
      2: return $urandom() & $urandom();
      default: return $urandom();
    endcase
  endfunction

  function automatic irq_req_t random_item();
    irq_req_t r;
    int unsigned pick;
    r.core    = 2'($urandom_range(3));
    r.line_en = $urandom_range(9) != 0;
    r.aff     = 4'($urandom_range(15));
    pick = $urandom_range(9);
    r.line = (pick < 4) ? 7'($urandom_range(9))
           : (pick < 9) ? 7'($urandom_range(TotalLines - 1))
           : 7'($urandom_range(127, TotalLines));
    case ($urandom_range(5))
      0: r.prio = '0;
      1: r.prio = UnusedPrio;
      2: r.prio = 8'($urandom_range(40));
      default: r.prio = 8'($urandom_range(255));
    endcase
    // Accept source shapes: empty, one line, cascade, or noise.
    case ($urandom_range(4))
      0: r.local_src = '0;
      1: r.local_src = 32'd1 << $urandom_range(31);
      2, 3: r.local_src = (32'd1 << CascadeBit) | ($urandom() & 32'hFF);
      default: r.local_src = $urandom();
    endcase
    r.bank0 = sparse_word();
    r.bank1 = sparse_word();
    r.basic = ($urandom_range(1) != 0) ? 8'($urandom()) : 8'd0;
    pick = $urandom_range(99);
    r.op = (pick < 30) ? OpSetLine
         : (pick < 55) ? OpAccept
         : (pick < 63) ? OpEoi
         : (pick < 72) ? OpSetPrio
         : (pick < 95) ? OpReadEn
         : 3'($urandom_range(7, 5));
    return r;
  endfunction

  // Drives one beat at a clock edge, waits for acceptance, then maybe idles.
  task automatic send_item(irq_req_t r);
    int unsigned gap;
    op_i            <= r.op;
    core_i          <= r.core;
    line_i          <= r.line;
    line_enable_i   <= r.line_en;
    priority_req_i  <= r.prio;
    affinity_i      <= r.aff;
    local_sources_i <= r.local_src;
    pending_bank0_i <= r.bank0;
    pending_bank1_i <= r.bank1;
    basic_pending_i <= r.basic;
    start           <= 1'b1;
    do @(posedge clk_i); while (busy);
    irq_sb.note_item(r);
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    irq_req_t directed[$];
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);

    // Table extremes, special lines, read-enables, each accept path, then priority changes and an unknown op.
    directed.push_back(mk(OpSetLine, 0, 0, 1, 10, 4'hF, 0, 0, 0, 0));
    directed.push_back(mk(OpSetLine, 0, 103, 1, 200, 4'h1, 0, 0, 0, 0));
    directed.push_back(mk(OpSetLine, 1, 4, 1, 50, 4'hF, 0, 0, 0, 0));
    directed.push_back(mk(OpSetLine, 2, 20, 1, 30, 4'hF, 0, 0, 0, 0));   // no enable bit
    directed.push_back(mk(OpSetLine, 0, 40, 1, UnusedPrio, 4'hF, 0, 0, 0, 0));
    directed.push_back(mk(OpSetLine, 3, 120, 1, 5, 4'hF, 0, 0, 0, 0));   // off the tables
    directed.push_back(mk(OpSetLine, 0, 60, 0, 9, 4'h8, 0, 0, 0, 0));
    directed.push_back(mk(OpReadEn, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OpReadEn, 0, 103, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OpReadEn, 1, 8, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OpReadEn, 2, 20, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OpReadEn, 3, 127, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OpAccept, 0, 0, 0, 0, 0, 0, 0, 0, 0));        // spurious
    directed.push_back(mk(OpAccept, 1, 0, 0, 0, 0, 32'h10, 0, 0, 0));   // mailbox
    directed.push_back(mk(OpAccept, 0, 0, 0, 0, 0, 32'h100, 0, 0, 8'h80));
    directed.push_back(mk(OpAccept, 2, 0, 0, 0, 0, 32'h108, 0, 0, 0));  // cascade falls back
    directed.push_back(mk(OpAccept, 3, 0, 0, 0, 0, 32'h100, 32'h8000_0000, '1, 0));
    directed.push_back(mk(OpAccept, 3, 0, 0, 0, 0, 32'h100, 0, 32'h1, 8'hFF));
    directed.push_back(mk(OpAccept, 2, 0, 0, 0, 0, 32'h100, 0, 0, 0));  // cascade, nothing
    directed.push_back(mk(OpAccept, 1, 0, 0, 0, 0, 32'h8000_0000, 0, 0, 0)); // unused line
    directed.push_back(mk(OpEoi, 0, 0, 0, 8'd0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OpSetPrio, 3, 0, 0, 8'hFF, 0, 0, 0, 0, 0));
    directed.push_back(mk(OpSetPrio, 2, 0, 0, 8'd0, 0, 0, 0, 0, 0));
    directed.push_back(mk(3'd7, 1, 127, 1, 8'hFF, 4'hF, '1, '1, '1, 8'hFF));
    directed.push_back(mk(OpAccept, 1, 0, 0, 0, 0, '1, '1, '1, 8'hFF));
    foreach (directed[i]) send_item(directed[i]);

    // Three idling phases: light, heavy, none.
    for (int i = 0; i < RandomBeats; i++) begin
      idle_pct = (i < RandomBeats / 3) ? 35 : (i < 2 * RandomBeats / 3) ? 73 : 0;
      send_item(random_item());
    end
    start <= 1'b0;

    while (irq_sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (irq_sb.errors == 0 && irq_sb.owed_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/pim_pkg.sv
hw/rtl/pim_ram.sv
hw/rtl/priority_interrupt_masker.sv
tb/sv/priority_interrupt_masker_tb.sv
